[design/dct_8x8_forward_defines.svh]
// Assertion macros for the 8x8 forward DCT block
`ifndef DCT_8X8_FORWARD_DEFINES_SVH
`define DCT_8X8_FORWARD_DEFINES_SVH

// same-cycle implication, held off during reset
`define DCT8F_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define DCT8F_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/dct8f_pkg.sv]
// Shared types, constants and cosine weight function for the 8x8 forward DCT
package dct8f_pkg;

    localparam int COEF_FRAC_BITS = 14;

    localparam int SAMPLE_W = 8;
    localparam int ADDR_W   = 6;
    localparam int IDX_W    = 3;
    localparam int STEP_W   = 9;
    localparam int COEF_W   = COEF_FRAC_BITS + 2;
    localparam int ROW_W    = COEF_FRAC_BITS + 12;
    localparam int PROD_W   = ROW_W + COEF_W;
    localparam int ACC_W    = 2 * COEF_FRAC_BITS + 15;
    localparam int MAG_W    = ACC_W - 1;
    localparam int NUM_W    = 6;
    localparam int T_W      = MAG_W + NUM_W - 2 * COEF_FRAC_BITS;
    localparam int W_W      = 15;
    localparam int RECIP_W  = 16;
    localparam int QPROD_W  = W_W + RECIP_W;
    localparam int RES_W    = 11;
    localparam int DRAIN_W  = 4;

    localparam logic [STEP_W-1:0]  LAST_STEP        = '1;
    localparam logic [ADDR_W-1:0]  LAST_FILL        = '1;
    localparam logic [IDX_W-1:0]   LAST_TAP         = '1;
    localparam logic [DRAIN_W-1:0] ROW_DRAIN_CYCLES = 4'd4;
    localparam logic [DRAIN_W-1:0] COL_DRAIN_CYCLES = 4'd12;

    // cos(m*pi/16), m = 0..8, Q30
    localparam logic [30:0] COS_Q30 [9] = '{
        31'd1073741824, 31'd1053110175, 31'd992008094, 31'd892783698, 31'd759250125,
        31'd596538995, 31'd410903207, 31'd209476638, 31'd0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_ROW_DRAIN,
        ST_COL,
        ST_COL_DRAIN
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SC_DC,
        SC_EDGE,
        SC_AC
    } scale_class_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
    } sample_wr_t;

    typedef struct packed {
        logic              valid;
        logic              col_pass;
        logic              first;
        logic              last;
        logic [ADDR_W-1:0] rd_addr;
        logic [IDX_W-1:0]  cos_k;
        logic [IDX_W-1:0]  cos_n;
        logic [ADDR_W-1:0] position;
    } mac_issue_t;

    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] sum;
        logic [ADDR_W-1:0]       position;
    } col_result_t;

    // c[k][n] = round(cos((2n+1)k*pi/16) * 2^COEF_FRAC_BITS), half away from zero
    function automatic logic signed [COEF_W-1:0] cos_weight(
        input logic [IDX_W-1:0] k,
        input logic [IDX_W-1:0] n
    );
        logic [6:0]        angle;
        logic [4:0]        m;
        logic [5:0]        diff;
        logic [3:0]        base;
        logic              neg;
        logic [30:0]       rounded;
        logic [30:0]       shifted;
        logic [COEF_W-1:0] mag;
        angle = 7'({n, 1'b1}) * 7'(k);
        m     = angle[4:0];
        diff  = '0;
        if (m <= 5'd8)
        begin
            base = m[3:0];
            neg  = 1'b0;
        end
        else if (m <= 5'd16)
        begin
            diff = 6'd16 - 6'(m);
            base = diff[3:0];
            neg  = 1'b1;
        end
        else if (m <= 5'd24)
        begin
            diff = 6'(m) - 6'd16;
            base = diff[3:0];
            neg  = 1'b1;
        end
        else
        begin
            diff = 6'd32 - 6'(m);
            base = diff[3:0];
            neg  = 1'b0;
        end
        rounded = COS_Q30[base] + (31'd1 << (29 - COEF_FRAC_BITS));
        shifted = rounded >> (30 - COEF_FRAC_BITS);
        mag     = shifted[COEF_W-1:0];
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

[design/dct8f_ctrl.sv]
// Sequencer: sample fill count, row and column pass step counters, drain waits
module dct8f_ctrl
    import dct8f_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output sample_wr_t sample_wr,
    output mac_issue_t issue
);

    ctrl_state_t        state_reg, state_next;
    logic [ADDR_W-1:0]  fill_reg, fill_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [DRAIN_W-1:0] drain_reg, drain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            step_reg  <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            step_reg  <= step_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        step_next      = step_reg;
        drain_next     = drain_reg;
        sample_wr.we   = 1'b0;
        sample_wr.addr = fill_reg;
        issue          = '0;
        busy           = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    sample_wr.we = 1'b1;
                    fill_next    = fill_reg + 1'b1;
                    if (fill_reg == LAST_FILL)
                    begin
                        state_next = ST_ROW;
                        step_next  = '0;
                    end
                end
            end
            ST_ROW:
            begin
                // step = {i, v, j}: R[i][v] += x[i][j] * c[v][j]
                issue.valid    = 1'b1;
                issue.col_pass = 1'b0;
                issue.first    = (step_reg[2:0] == '0);
                issue.last     = (step_reg[2:0] == LAST_TAP);
                issue.rd_addr  = {step_reg[8:6], step_reg[2:0]};
                issue.cos_k    = step_reg[5:3];
                issue.cos_n    = step_reg[2:0];
                issue.position = step_reg[8:3];
                step_next      = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_ROW_DRAIN;
                    drain_next = '0;
                end
            end
            ST_ROW_DRAIN:
            begin
                // interlock: last row sums reach the store before the column pass reads
                drain_next = drain_reg + 1'b1;
                if (drain_reg == ROW_DRAIN_CYCLES - 1'b1)
                begin
                    state_next = ST_COL;
                    step_next  = '0;
                end
            end
            ST_COL:
            begin
                // step = {u, v, i}: S[u][v] += c[u][i] * R[i][v]
                issue.valid    = 1'b1;
                issue.col_pass = 1'b1;
                issue.first    = (step_reg[2:0] == '0);
                issue.last     = (step_reg[2:0] == LAST_TAP);
                issue.rd_addr  = {step_reg[2:0], step_reg[5:3]};
                issue.cos_k    = step_reg[8:6];
                issue.cos_n    = step_reg[2:0];
                issue.position = step_reg[8:3];
                step_next      = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_COL_DRAIN;
                    drain_next = '0;
                end
            end
            ST_COL_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == COL_DRAIN_CYCLES - 1'b1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/dct8f_mac.sv]
// Sample and row-sum stores with the shared multiply-accumulate pipeline
module dct8f_mac
    import dct8f_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  sample_wr_t          sample_wr,
    input  logic [SAMPLE_W-1:0] pixel,
    input  mac_issue_t          issue,
    output col_result_t         col_res
);

    logic [SAMPLE_W-1:0]     sample_mem [2**ADDR_W];
    logic signed [ROW_W-1:0] row_mem    [2**ADDR_W];

    logic [SAMPLE_W-1:0]      sample_rd_reg;
    logic signed [ROW_W-1:0]  row_rd_reg;
    logic signed [COEF_W-1:0] cos_reg;
    logic                     s1_valid_reg, s1_col_reg, s1_first_reg, s1_last_reg;
    logic [ADDR_W-1:0]        s1_pos_reg;

    logic signed [ROW_W-1:0]  operand;
    logic signed [PROD_W-1:0] prod_next, prod_reg;
    logic                     s2_valid_reg, s2_col_reg, s2_first_reg, s2_last_reg;
    logic [ADDR_W-1:0]        s2_pos_reg;

    logic signed [ACC_W-1:0]  acc_next, acc_reg;
    logic signed [ACC_W-1:0]  res_sum_reg;
    logic                     res_valid_reg, res_col_reg;
    logic [ADDR_W-1:0]        res_pos_reg;

    always_ff @(posedge clk)
    begin
        if (sample_wr.we)
        begin
            sample_mem[sample_wr.addr] <= pixel;
        end
        sample_rd_reg <= sample_mem[issue.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (res_valid_reg && !res_col_reg)
        begin
            row_mem[res_pos_reg] <= res_sum_reg[ROW_W-1:0];
        end
        row_rd_reg <= row_mem[issue.rd_addr];
    end

    // level shift by 128 is an inversion of the top bit
    assign operand   = s1_col_reg ? row_rd_reg
                                  : ROW_W'($signed({~sample_rd_reg[SAMPLE_W-1],
                                                    sample_rd_reg[SAMPLE_W-2:0]}));
    assign prod_next = operand * cos_reg;
    assign acc_next  = s2_first_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= issue.valid;
            s2_valid_reg  <= s1_valid_reg;
            res_valid_reg <= s2_valid_reg && s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg      <= cos_weight(issue.cos_k, issue.cos_n);
        s1_col_reg   <= issue.col_pass;
        s1_first_reg <= issue.first;
        s1_last_reg  <= issue.last;
        s1_pos_reg   <= issue.position;

        prod_reg     <= prod_next;
        s2_col_reg   <= s1_col_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_pos_reg   <= s1_pos_reg;

        acc_reg      <= acc_next;
        res_sum_reg  <= acc_next;
        res_col_reg  <= s2_col_reg;
        res_pos_reg  <= s2_pos_reg;
    end

    assign col_res.valid    = res_valid_reg && res_col_reg;
    assign col_res.sum      = res_sum_reg;
    assign col_res.position = res_pos_reg;

endmodule

[design/dct8f_scale.sv]
// Scaling, truncating division by constant and saturation of column sums
module dct8f_scale
    import dct8f_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  col_result_t              col_res,
    output logic                     strobe,
    output logic signed [RES_W-1:0]  coefficient,
    output logic [ADDR_W-1:0]        position,
    output logic                     last_of_block
);

    scale_class_t      cls_next;
    logic [MAG_W-1:0]  mag_next;
    logic signed [ACC_W-1:0] neg_sum;

    logic              s1_valid_reg, s1_neg_reg;
    scale_class_t      s1_cls_reg;
    logic [ADDR_W-1:0] s1_pos_reg;
    logic [MAG_W-1:0]  s1_mag_reg;

    logic [NUM_W-1:0]       num;
    logic [MAG_W+NUM_W-1:0] scaled;
    logic                   s2_valid_reg, s2_neg_reg;
    scale_class_t           s2_cls_reg;
    logic [ADDR_W-1:0]      s2_pos_reg;
    logic [T_W-1:0]         s2_t_reg;

    logic [T_W-1:0]    shifted, limit;
    logic [W_W-1:0]    w_next;
    logic              s3_valid_reg, s3_neg_reg;
    scale_class_t      s3_cls_reg;
    logic [ADDR_W-1:0] s3_pos_reg;
    logic [W_W-1:0]    s3_w_reg;

    logic [RECIP_W-1:0] recip;
    logic              s4_valid_reg, s4_neg_reg;
    scale_class_t      s4_cls_reg;
    logic [ADDR_W-1:0] s4_pos_reg;
    logic [QPROD_W-1:0] s4_prod_reg;

    logic [QPROD_W-1:0]      quot_full;
    logic [RES_W-1:0]        quot;
    logic signed [RES_W-1:0] coef_next;

    logic                    strobe_reg;
    logic signed [RES_W-1:0] coefficient_reg;
    logic [ADDR_W-1:0]       position_reg;
    logic                    last_reg;

    // weights aU*aV/40000: 49/400 at DC, 7/40 on the first row or column, 1/4 elsewhere
    always_comb
    begin
        priority if (col_res.position == '0)
            cls_next = SC_DC;
        else if (col_res.position[5:3] == '0 || col_res.position[2:0] == '0)
            cls_next = SC_EDGE;
        else
            cls_next = SC_AC;
    end

    assign neg_sum  = -col_res.sum;
    assign mag_next = col_res.sum[ACC_W-1] ? neg_sum[MAG_W-1:0] : col_res.sum[MAG_W-1:0];

    always_comb
    begin
        unique case (s1_cls_reg)
            SC_DC:   num = 6'd49;
            SC_EDGE: num = 6'd7;
            SC_AC:   num = 6'd1;
            default: num = 6'd1;
        endcase
    end

    assign scaled = s1_mag_reg * (MAG_W + NUM_W)'(num);

    // den = 400 = 16*25, 40 = 8*5, 4 = 4*1: shift first, then divide by 25, 5 or 1
    always_comb
    begin
        unique case (s2_cls_reg)
            SC_DC:
            begin
                shifted = s2_t_reg >> 4;
                limit   = T_W'(25625);
            end
            SC_EDGE:
            begin
                shifted = s2_t_reg >> 3;
                limit   = T_W'(5125);
            end
            SC_AC:
            begin
                shifted = s2_t_reg >> 2;
                limit   = T_W'(1025);
            end
            default:
            begin
                shifted = s2_t_reg >> 2;
                limit   = T_W'(1025);
            end
        endcase
    end

    // anything at or beyond 1025 quotients saturates either way
    assign w_next = (shifted >= limit) ? limit[W_W-1:0] : shifted[W_W-1:0];

    always_comb
    begin
        unique case (s3_cls_reg)
            SC_DC:   recip = 16'd41944;
            SC_EDGE: recip = 16'd52429;
            SC_AC:   recip = 16'd1;
            default: recip = 16'd1;
        endcase
    end

    always_comb
    begin
        unique case (s4_cls_reg)
            SC_DC:   quot_full = s4_prod_reg >> 20;
            SC_EDGE: quot_full = s4_prod_reg >> 18;
            SC_AC:   quot_full = s4_prod_reg;
            default: quot_full = s4_prod_reg;
        endcase
        quot = quot_full[RES_W-1:0];
        if (s4_neg_reg)
            coef_next = (quot > 11'd1024) ? -11'sd1024 : -$signed(quot);
        else
            coef_next = (quot > 11'd1023) ? 11'sd1023 : $signed(quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= col_res.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            strobe_reg   <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_neg_reg      <= col_res.sum[ACC_W-1];
        s1_cls_reg      <= cls_next;
        s1_pos_reg      <= col_res.position;
        s1_mag_reg      <= mag_next;

        s2_neg_reg      <= s1_neg_reg;
        s2_cls_reg      <= s1_cls_reg;
        s2_pos_reg      <= s1_pos_reg;
        s2_t_reg        <= scaled[MAG_W+NUM_W-1:2*COEF_FRAC_BITS];

        s3_neg_reg      <= s2_neg_reg;
        s3_cls_reg      <= s2_cls_reg;
        s3_pos_reg      <= s2_pos_reg;
        s3_w_reg        <= w_next;

        s4_neg_reg      <= s3_neg_reg;
        s4_cls_reg      <= s3_cls_reg;
        s4_pos_reg      <= s3_pos_reg;
        s4_prod_reg     <= QPROD_W'(s3_w_reg) * QPROD_W'(recip);

        coefficient_reg <= coef_next;
        position_reg    <= s4_pos_reg;
        last_reg        <= s4_valid_reg && (s4_pos_reg == LAST_FILL);
    end

    assign strobe        = strobe_reg;
    assign coefficient   = coefficient_reg;
    assign position      = position_reg;
    assign last_of_block = last_reg;

endmodule

[design/dct_8x8_forward.sv]
// Forward 8x8 DCT: 64 samples in, 64 coefficients out in row-major order
// A sample is accepted whenever start is high while a block fills; the 64th starts the transform.
// A row pass then a column pass run on one multiply-accumulate unit, each followed by a drain wait;
// busy stays high through both, and each coefficient follows the eighth product of its column sum.
// Samples of the next block are accepted only once busy falls; the receiver cannot stall.
// Reset clears the sequencer and fill count; the stores hold no reset value.
module dct_8x8_forward
    import dct8f_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [SAMPLE_W-1:0]     pixel,
    output logic                    strobe,
    output logic signed [RES_W-1:0] coefficient,
    output logic [ADDR_W-1:0]       position,
    output logic                    last_of_block
);

    sample_wr_t  sample_wr;
    mac_issue_t  issue;
    col_result_t col_res;

    dct8f_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample_wr (sample_wr),
        .issue     (issue)
    );

    dct8f_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_wr (sample_wr),
        .pixel     (pixel),
        .issue     (issue),
        .col_res   (col_res)
    );

    dct8f_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .col_res       (col_res),
        .strobe        (strobe),
        .coefficient   (coefficient),
        .position      (position),
        .last_of_block (last_of_block)
    );

endmodule

[design/dct8f_checker.sv]
// Port-level checks on result ordering and busy for the 8x8 forward DCT
`include "dct_8x8_forward_defines.svh"

module dct8f_checker
    import dct8f_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              strobe,
    input logic [ADDR_W-1:0] position,
    input logic              last_of_block
);

    `DCT8F_ASSERT_IMPLY(a_strobe_while_busy, clk, rst_n, strobe, busy, "result outside busy window")
    `DCT8F_ASSERT_IMPLY(a_last_at_end, clk, rst_n, last_of_block, strobe && (position == LAST_FILL), "last flag misplaced")
    `DCT8F_ASSERT_IMPLY(a_in_order, clk, rst_n, strobe && (position != '0), $past(strobe, 8) && ($past(position, 8) == position - 6'd1), "coefficient order broken")
    `DCT8F_ASSERT_NEXT(a_spaced, clk, rst_n, strobe, !strobe, "back-to-back result transactions")

endmodule

bind dct_8x8_forward dct8f_checker u_dct8f_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .busy          (busy),
    .strobe        (strobe),
    .position      (position),
    .last_of_block (last_of_block)
);

[tb/sv/dct_coef_checker.sv]
// Checker for the 8x8 forward DCT: collects accepted samples, predicts coefficients, compares
module dct_coef_checker
    import dct8f_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [SAMPLE_W-1:0]     pixel,
    input  logic                    strobe,
    input  logic signed [RES_W-1:0] coefficient,
    input  logic [ADDR_W-1:0]       position,
    input  logic                    last_of_block,
    output int                      failures,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [RES_W-1:0] coef;
        logic [ADDR_W-1:0]       pos;
        logic                    last;
    } coef_rec_t;

    // cos(m*pi/16), m = 0..8, Q30
    localparam longint COS_TAB_Q30 [9] = '{
        64'd1073741824, 64'd1053110175, 64'd992008094, 64'd892783698, 64'd759250125,
        64'd596538995, 64'd410903207, 64'd209476638, 64'd0
    };

    coef_rec_t           expected_coefs [$];
    logic [SAMPLE_W-1:0] block_pixels [64];
    int                  samples_held;
    int                  mismatches_shown;
    coef_rec_t           want;

    function automatic longint basis_weight(int k, int n);
        int     m;
        int     base;
        bit     neg;
        longint mag;
        m = ((2 * n + 1) * k) % 32;
        if (m <= 8)
        begin
            base = m;
            neg  = 1'b0;
        end
        else if (m <= 16)
        begin
            base = 16 - m;
            neg  = 1'b1;
        end
        else if (m <= 24)
        begin
            base = m - 16;
            neg  = 1'b1;
        end
        else
        begin
            base = 32 - m;
            neg  = 1'b0;
        end
        mag = (COS_TAB_Q30[base] + (64'sd1 << (29 - COEF_FRAC_BITS))) >>> (30 - COEF_FRAC_BITS);
        return neg ? -mag : mag;
    endfunction

    // weights 0.49, 0.7 and 1.0 over 4, floored on the magnitude, then clipped
    function automatic logic signed [RES_W-1:0] scale_and_clip(longint s, int u, int v);
        longint                  num;
        longint                  den;
        longint                  mag;
        longint                  q;
        logic signed [RES_W-1:0] r;
        if (u == 0 && v == 0)
        begin
            num = 49;
            den = 400;
        end
        else if (u == 0 || v == 0)
        begin
            num = 7;
            den = 40;
        end
        else
        begin
            num = 1;
            den = 4;
        end
        mag = (s < 0) ? -s : s;
        q   = ((mag * num) >>> (2 * COEF_FRAC_BITS)) / den;
        if (s < 0)
            r = (q > 1024) ? -11'sd1024 : RES_W'(-q);
        else
            r = (q > 1023) ? 11'sd1023 : RES_W'(q);
        return r;
    endfunction

    task automatic predict_block();
        longint    row_sum [64];
        longint    acc;
        coef_rec_t rec;
        for (int i = 0; i < 8; i++)
            for (int v = 0; v < 8; v++)
            begin
                acc = 0;
                for (int j = 0; j < 8; j++)
                    acc += (longint'(block_pixels[i * 8 + j]) - 128) * basis_weight(v, j);
                row_sum[i * 8 + v] = acc;
            end
        for (int u = 0; u < 8; u++)
            for (int v = 0; v < 8; v++)
            begin
                acc = 0;
                for (int i = 0; i < 8; i++)
                    acc += basis_weight(u, i) * row_sum[i * 8 + v];
                rec.coef = scale_and_clip(acc, u, v);
                rec.pos  = ADDR_W'(u * 8 + v);
                rec.last = (u == 7 && v == 7);
                expected_coefs.push_back(rec);
            end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_held     = 0;
            failures         = 0;
            pending          = 0;
            mismatches_shown = 0;
            expected_coefs.delete();
        end
        else
        begin
            if (strobe)
            begin
                if (expected_coefs.size() == 0)
                begin
                    failures++;
                    if (mismatches_shown < 10)
                        $display("unexpected coefficient %0d at position %0d, last %0b",
                                 coefficient, position, last_of_block);
                    mismatches_shown++;
                end
                else
                begin
                    want = expected_coefs.pop_front();
                    if (want.coef !== coefficient || want.pos !== position ||
                        want.last !== last_of_block)
                    begin
                        failures++;
                        if (mismatches_shown < 10)
                            $display("mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                     want.coef, want.pos, want.last,
                                     coefficient, position, last_of_block);
                        mismatches_shown++;
                    end
                end
            end
            if (start && !busy)
            begin
                block_pixels[samples_held] = pixel;
                samples_held++;
                if (samples_held == 64)
                begin
                    predict_block();
                    samples_held = 0;
                end
            end
            pending = expected_coefs.size();
        end
    end

endmodule

[tb/sv/dct_8x8_forward_test.sv]
// Top of the 8x8 forward DCT testbench: clock, reset, sample stimulus and verdict
module dct_8x8_forward_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dct8f_pkg::*;

    typedef enum int {
        PAT_DARK,
        PAT_BRIGHT,
        PAT_CHECK_POS,
        PAT_CHECK_NEG,
        PAT_UNIFORM,
        PAT_EXTREME
    } block_pattern_t;

    // sign of the middle-frequency basis row: + - - + + - - +
    localparam logic [7:0] MID_SIGN = 8'b1001_1001;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic [SAMPLE_W-1:0]     pixel = '0;
    logic                    busy;
    logic                    strobe;
    logic signed [RES_W-1:0] coefficient;
    logic [ADDR_W-1:0]       position;
    logic                    last_of_block;
    int                      failures;
    int                      pending;

    dct_8x8_forward dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .pixel         (pixel),
        .strobe        (strobe),
        .coefficient   (coefficient),
        .position      (position),
        .last_of_block (last_of_block)
    );

    dct_coef_checker coef_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .pixel         (pixel),
        .strobe        (strobe),
        .coefficient   (coefficient),
        .position      (position),
        .last_of_block (last_of_block),
        .failures      (failures),
        .pending       (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("dct_8x8_forward_test: done, errors");
        $finish;
    end

    function automatic logic [SAMPLE_W-1:0] block_pixel(block_pattern_t pat, int idx);
        logic agree;
        agree = MID_SIGN[idx / 8] ~^ MID_SIGN[idx % 8];
        case (pat)
            PAT_DARK:      return 8'd0;
            PAT_BRIGHT:    return 8'd255;
            PAT_CHECK_POS: return agree ? 8'd255 : 8'd0;
            PAT_CHECK_NEG:
                if ($urandom_range(0, 7) == 0)
                    return SAMPLE_W'($urandom_range(0, 255));
                else
                    return agree ? 8'd0 : 8'd255;
            PAT_EXTREME:
                case ($urandom_range(0, 5))
                    0:       return 8'd0;
                    1:       return 8'd255;
                    2:       return 8'd1;
                    3:       return 8'd254;
                    4:       return 8'd127;
                    default: return 8'd128;
                endcase
            default:       return SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // entered and left at a falling edge; the transaction completes at the final rising edge inside the task
    task automatic send_pixel(logic [SAMPLE_W-1:0] value, bit no_idle);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        pixel <= value;
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic send_block(block_pattern_t pat);
        bit no_idle;
        no_idle = ($urandom_range(0, 2) == 0);
        for (int idx = 0; idx < 64; idx++)
            send_pixel(block_pixel(pat, idx), no_idle);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_block(PAT_DARK);
        send_block(PAT_BRIGHT);
        send_block(PAT_CHECK_POS);
        drain_results();

        send_block(PAT_UNIFORM);
        send_block(PAT_EXTREME);
        send_block(PAT_CHECK_NEG);

        drain_results();
        repeat (1200) @(negedge clk);
        if (failures == 0 && pending == 0)
            $display("dct_8x8_forward_test: done, clean");
        else
            $display("dct_8x8_forward_test: done, errors");
        $finish;
    end

endmodule
